### rtl/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg - shared types and constants for the role election block
// Event and result codes, role encoding, and the structs that carry state,
// configuration, events and results between the modules.
// ----------------------------------------------------------------------------
package cre_pkg;

  localparam int TermWidth = 31;
  localparam int NodeWidth = 4;
  localparam int VoteWidth = 4;

  // Largest cluster the majority rule honors
  localparam logic [NodeWidth-1:0] MAX_CLUSTER = 4'd15;
  // Vote counter saturates here
  localparam logic [VoteWidth-1:0] VOTES_MAX   = 4'd15;
  // Term saturates here
  localparam logic [TermWidth-1:0] TERM_MAX    = {TermWidth{1'b1}};

  // Reset values of the configuration registers
  localparam logic [NodeWidth-1:0] RESET_OWN_NODE_ID  = 4'd0;
  localparam logic [NodeWidth-1:0] RESET_CLUSTER_SIZE = 4'd3;

  // Configuration register indexes
  localparam logic CFG_OWN_NODE_ID  = 1'b0;
  localparam logic CFG_CLUSTER_SIZE = 1'b1;

  // Node role
  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  // Incoming event codes; codes 6 and 7 are ignored
  typedef enum logic [2:0] {
    FUNC_VOTE_REQ      = 3'd0,
    FUNC_VOTE_REPLY    = 3'd1,
    FUNC_APPEND_REQ    = 3'd2,
    FUNC_APPEND_REPLY  = 3'd3,
    FUNC_ELECT_TIMEOUT = 3'd4,
    FUNC_HEARTBEAT     = 3'd5
  } func_t;

  // Outgoing message kinds
  typedef enum logic [2:0] {
    SEND_NONE         = 3'd0,
    SEND_VOTE_REQ     = 3'd1,
    SEND_VOTE_REPLY   = 3'd2,
    SEND_APPEND_REPLY = 3'd3,
    SEND_HEARTBEAT    = 3'd4
  } send_t;

  typedef struct packed {
    role_t                 role;
    logic [TermWidth-1:0]  term;
    logic [NodeWidth-1:0]  vote_target;
    logic                  vote_cast;
    logic [VoteWidth-1:0]  votes_counted;
  } cre_state_t;

  typedef struct packed {
    logic [NodeWidth-1:0] own_node_id;
    logic [NodeWidth-1:0] cluster_size;
  } cre_cfg_t;

  typedef struct packed {
    logic [2:0]           func;
    logic [TermWidth-1:0] msg_term;
    logic [NodeWidth-1:0] msg_candidate;
    logic                 msg_flag;
  } cre_event_t;

  typedef struct packed {
    send_t                send_kind;
    logic [TermWidth-1:0] term;
    logic                 flag;
    logic [NodeWidth-1:0] node;
    role_t                role;
  } cre_result_t;

endpackage

### rtl/cre_cfg_regs.sv
// ----------------------------------------------------------------------------
// cre_cfg_regs - configuration registers
// Holds own node id and cluster size; a write lands every cycle it is offered.
// ----------------------------------------------------------------------------
module cre_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [cre_pkg::NodeWidth-1:0]    cfg_data,
  output cre_pkg::cre_cfg_t                cfg
);
  import cre_pkg::*;

  // always able to take a write
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_node_id  <= RESET_OWN_NODE_ID;
      cfg.cluster_size <= RESET_CLUSTER_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_NODE_ID:  cfg.own_node_id  <= cfg_data;
        CFG_CLUSTER_SIZE: cfg.cluster_size <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/cre_step.sv
// ----------------------------------------------------------------------------
// cre_step - election step logic
// From the current state, configuration and one event, computes the next
// state and the message to send.
// ----------------------------------------------------------------------------
module cre_step (
  input  cre_pkg::cre_state_t  state,
  input  cre_pkg::cre_cfg_t    cfg,
  input  cre_pkg::cre_event_t  ev,
  output cre_pkg::cre_state_t  state_next,
  output cre_pkg::cre_result_t result
);
  import cre_pkg::*;

  logic                 term_hi;
  logic                 term_eq;
  logic                 grant;
  logic [VoteWidth-1:0] votes_inc;
  logic [NodeWidth-1:0] size_eff;
  logic [NodeWidth-2:0] votes_half;
  logic                 reply_win;
  logic                 self_win;
  logic [TermWidth-1:0] term_inc;

  // term compares
  assign term_hi = ev.msg_term > state.term;
  assign term_eq = ev.msg_term == state.term;

  // vote grant: term matches after adoption, and no other candidate holds the vote
  assign grant = (term_hi || term_eq) &&
                 (term_hi || !state.vote_cast || (state.vote_target == ev.msg_candidate));

  // vote counting with saturation
  assign votes_inc = (ev.msg_flag && (state.votes_counted != VOTES_MAX)) ?
                     state.votes_counted + VoteWidth'(1) : state.votes_counted;

  // majority: votes exceed half the (clamped) cluster size
  assign size_eff   = (cfg.cluster_size > MAX_CLUSTER) ? MAX_CLUSTER : cfg.cluster_size;
  assign votes_half = size_eff[NodeWidth-1:1];
  assign reply_win  = votes_inc > {1'b0, votes_half};
  assign self_win   = VoteWidth'(1) > {1'b0, votes_half};

  // saturating term increment
  assign term_inc = (state.term != TERM_MAX) ? state.term + TermWidth'(1) : state.term;

  // next state
  always_comb begin
    state_next = state;
    unique case (func_t'(ev.func))
      FUNC_VOTE_REQ: begin
        if (term_hi) begin
          state_next.role      = ROLE_FOLLOWER;
          state_next.term      = ev.msg_term;
          state_next.vote_cast = 1'b0;
        end
        if (grant) begin
          state_next.vote_cast   = 1'b1;
          state_next.vote_target = ev.msg_candidate;
        end
      end
      FUNC_VOTE_REPLY: begin
        if (state.role == ROLE_CANDIDATE) begin
          if (term_hi) begin
            state_next.role      = ROLE_FOLLOWER;
            state_next.term      = ev.msg_term;
            state_next.vote_cast = 1'b0;
          end else if (term_eq) begin
            if (reply_win) begin
              state_next.role          = ROLE_LEADER;
              state_next.votes_counted = '0;
            end else begin
              state_next.votes_counted = votes_inc;
            end
          end
        end
      end
      FUNC_APPEND_REQ: begin
        if (term_hi) begin
          state_next.term      = ev.msg_term;
          state_next.vote_cast = 1'b0;
        end
        if (term_hi || term_eq) begin
          state_next.role = ROLE_FOLLOWER;
        end
      end
      FUNC_APPEND_REPLY: begin
        if (term_hi) begin
          state_next.role      = ROLE_FOLLOWER;
          state_next.term      = ev.msg_term;
          state_next.vote_cast = 1'b0;
        end
      end
      FUNC_ELECT_TIMEOUT: begin
        if (state.role != ROLE_LEADER) begin
          state_next.term        = term_inc;
          state_next.vote_cast   = 1'b1;
          state_next.vote_target = cfg.own_node_id;
          if (self_win) begin
            state_next.role          = ROLE_LEADER;
            state_next.votes_counted = '0;
          end else begin
            state_next.role          = ROLE_CANDIDATE;
            state_next.votes_counted = VoteWidth'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // outgoing message
  always_comb begin
    result.send_kind = SEND_NONE;
    result.term      = state_next.term;
    result.flag      = 1'b0;
    result.node      = '0;
    result.role      = state_next.role;
    unique case (func_t'(ev.func))
      FUNC_VOTE_REQ: begin
        result.send_kind = SEND_VOTE_REPLY;
        result.flag      = grant;
      end
      FUNC_VOTE_REPLY: begin
        if (state_next.role == ROLE_LEADER) begin
          result.send_kind = SEND_HEARTBEAT;
          result.node      = cfg.own_node_id;
        end
      end
      FUNC_APPEND_REQ: begin
        result.send_kind = SEND_APPEND_REPLY;
        result.flag      = term_hi || term_eq;
      end
      FUNC_ELECT_TIMEOUT: begin
        if (state.role != ROLE_LEADER) begin
          result.send_kind = SEND_VOTE_REQ;
          result.node      = cfg.own_node_id;
        end
      end
      FUNC_HEARTBEAT: begin
        if (state.role == ROLE_LEADER) begin
          result.send_kind = SEND_HEARTBEAT;
          result.node      = cfg.own_node_id;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/consensus_role_election_fsm.sv
// ----------------------------------------------------------------------------
// consensus_role_election_fsm - leader election state machine for one node
// Event in, one outgoing message descriptor out per event.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel (evt_valid/evt_stall): one received message or timer expiry
//   per item. Result channel (res_valid/res_stall): exactly one item per
//   event, carrying the message to send, the current term and the new role.
//   Config channel (cfg_valid/cfg_ready): own node id (index 0) and cluster
//   size (index 1); write only while no event is in flight.
// Pipeline: two register stages, the event register and the result register.
// Throughput: one event per cycle while no result is held under res_stall;
//   the role/term/vote registers update in the cycle the event moves from
//   the event register to the result register.
// Stall: while the result register holds an item under res_stall, the event
//   register still takes one item; evt_stall rises only when both are full.
// Reset: synchronous; role follower, term 0, no vote cast, count 0,
//   own node id 0, cluster size 3, both stages empty.
// ----------------------------------------------------------------------------
module consensus_role_election_fsm (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [cre_pkg::NodeWidth-1:0]  cfg_data,
  // events
  input  logic                           evt_valid,
  output logic                           evt_stall,
  input  logic [2:0]                     func,
  input  logic [cre_pkg::TermWidth-1:0]  msg_term,
  input  logic [cre_pkg::NodeWidth-1:0]  msg_candidate,
  input  logic                           msg_flag,
  // results
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [2:0]                     send_kind,
  output logic [cre_pkg::TermWidth-1:0]  out_term,
  output logic                           out_flag,
  output logic [cre_pkg::NodeWidth-1:0]  out_node,
  output logic [1:0]                     role_now
);
  import cre_pkg::*;

  cre_cfg_t    cfg;
  cre_event_t  ev;
  logic        ev_valid;
  cre_state_t  state;
  cre_state_t  state_next;
  cre_result_t result;
  cre_result_t res;
  logic        res_free;
  logic        evt_accept;

  cre_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake
  assign res_free   = !res_valid || !res_stall;
  assign evt_stall  = ev_valid && !res_free;
  assign evt_accept = evt_valid && !evt_stall;

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!evt_stall) begin
      ev_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_accept) begin
      ev.func          <= func;
      ev.msg_term      <= msg_term;
      ev.msg_candidate <= msg_candidate;
      ev.msg_flag      <= msg_flag;
    end
  end

  cre_step u_step (
    .state      (state),
    .cfg        (cfg),
    .ev         (ev),
    .state_next (state_next),
    .result     (result)
  );

  // election state, updated as each event retires
  always_ff @(posedge clk) begin
    if (rst) begin
      state.role          <= ROLE_FOLLOWER;
      state.term          <= '0;
      state.vote_target   <= '0;
      state.vote_cast     <= 1'b0;
      state.votes_counted <= '0;
    end else if (ev_valid && res_free) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && res_free) begin
      res <= result;
    end
  end

  assign send_kind = res.send_kind;
  assign out_term  = res.term;
  assign out_flag  = res.flag;
  assign out_node  = res.node;
  assign role_now  = res.role;

endmodule

### rtl/cre_checker.sv
// ----------------------------------------------------------------------------
// cre_checker - port-level checks for the role election block
// Watches the top level's ports and flags ordering and consistency slips.
// ----------------------------------------------------------------------------
module cre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           cfg_index,
  input logic [cre_pkg::NodeWidth-1:0]  cfg_data,
  input logic                           evt_stall,
  input logic                           res_valid,
  input logic                           res_stall,
  input logic [2:0]                     send_kind,
  input logic [cre_pkg::TermWidth-1:0]  out_term,
  input logic                           out_flag,
  input logic [cre_pkg::NodeWidth-1:0]  out_node,
  input logic [1:0]                     role_now
);
  import cre_pkg::*;

  logic [TermWidth-1:0] last_term;
  logic [NodeWidth-1:0] own_id;

  // shadow of the last delivered term and of the node id
  always_ff @(posedge clk) begin
    if (rst) begin
      last_term <= '0;
      own_id    <= RESET_OWN_NODE_ID;
    end else begin
      if (res_valid && !res_stall) begin
        last_term <= out_term;
      end
      if (cfg_valid && cfg_ready && (cfg_index == CFG_OWN_NODE_ID)) begin
        own_id <= cfg_data;
      end
    end
  end

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(send_kind) && $stable(out_term)
      && $stable(out_flag) && $stable(out_node) && $stable(role_now))
    else $error("result changed while stalled");

  // term never goes backward across delivered items
  a_term_mono: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall |-> out_term >= last_term)
    else $error("term decreased");

  // broadcasts carry the configured node id
  a_bcast_node: assert property (@(posedge clk) disable iff (rst)
    res_valid && (send_kind == SEND_VOTE_REQ || send_kind == SEND_HEARTBEAT)
      |-> out_node == own_id)
    else $error("broadcast node id mismatch");

  // events back up only when a result is held
  a_evt_stall: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> res_valid && res_stall)
    else $error("event stall without result stall");

endmodule

bind consensus_role_election_fsm cre_checker u_cre_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .evt_stall (evt_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .send_kind (send_kind),
  .out_term  (out_term),
  .out_flag  (out_flag),
  .out_node  (out_node),
  .role_now  (role_now)
);
